### rtl/core/sorted_list_intersection_macros.svh
// Assertion macros of the checker file of the list intersection block.
`ifndef SORTED_LIST_INTERSECTION_MACROS_SVH
`define SORTED_LIST_INTERSECTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sli assertion failed");

// Next-cycle implication, disabled during reset.
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sli assertion failed");

`endif

### rtl/core/sli_pkg.sv
// Shared types and constants of the sorted list intersection block.
package sli_pkg;

  localparam int MAX_LISTS_DEF  = 8;
  localparam int LIST_DEPTH_DEF = 4096;
  localparam int ACT_W   = 2;
  localparam int ID_W    = 3;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_PROBE = 2'd2
  } sli_action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SRCH,
    ST_CHECK
  } sli_state_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [ID_W-1:0]    list_id;
    logic [VALUE_W-1:0] value;
  } sli_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] probe_value;
    logic               in_all;
    logic               overflow_seen;
  } sli_out_t;

endpackage

### rtl/core/sorted_list_intersection.sv
// Top level of the sorted list intersection engine.
//
// Requests enter on in_req when start is high and busy is low. A clear empties
// every stored list and the overflow flag; a load appends value to list_id.
// Busy stays low for both, so requests can follow back to back.
// A probe is looked up by lower-bound binary search in lists 0 .. other_lists-1
// and answers with one out_valid strobe carrying the value, in_all and the
// overflow flag. With no lists configured the strobe comes the cycle after
// acceptance. Otherwise each list costs a setup step, the steps of the binary
// search and a check step, all paced by the single port of the list memory (one
// read per cycle); the strobe follows the last of them and busy drops with it.
// A miss in any list ends the probe at once.
// cfg_data sets other_lists (values above MAX_LISTS act as MAX_LISTS); write it
// only while idle. The result is shown for one cycle and cannot be held off.
// Reset empties all lists, clears the overflow flag and other_lists, and the
// block is ready in the next cycle; the memory itself is never cleared.
module sorted_list_intersection #(
  parameter int MAX_LISTS  = sli_pkg::MAX_LISTS_DEF,
  parameter int LIST_DEPTH = sli_pkg::LIST_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  sli_pkg::sli_in_t           in_req,
  output logic                       out_valid,
  output sli_pkg::sli_out_t          out_res,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sli_pkg::CFG_W-1:0]  cfg_data
);

  localparam int LIST_W = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int CNT_W  = $clog2(MAX_LISTS + 1);
  localparam int IDX_W  = $clog2(LIST_DEPTH);
  localparam int LEN_W  = $clog2(LIST_DEPTH + 1);
  localparam int AW     = LIST_W + IDX_W;
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(LIST_DEPTH);

  sli_pkg::sli_state_t state_r, state_nxt;

  logic [LEN_W-1:0]           len_r [MAX_LISTS];
  logic                       ovf_r, ovf_nxt;
  logic [sli_pkg::CFG_W-1:0]  other_r;
  logic [LIST_W-1:0]          list_r, list_nxt;
  logic [CNT_W-1:0]           n_r, n_nxt;
  logic [LEN_W-1:0]           lo_r, lo_nxt;
  logic [LEN_W-1:0]           cnt_r, cnt_nxt;
  logic [LEN_W-1:0]           step_r, step_nxt;
  logic [LEN_W-1:0]           cur_len_r, cur_len_nxt;
  logic [sli_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic                       out_valid_r, out_valid_nxt;
  sli_pkg::sli_out_t          out_res_r, out_res_nxt;

  logic                       len_clr, len_inc;
  logic [LIST_W-1:0]          len_idx;
  logic [LEN_W-1:0]           len_sel;
  logic                       id_ok;
  logic [CNT_W-1:0]           n_cur;

  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  logic [sli_pkg::VALUE_W-1:0] ram_rdata;

  logic                       lt;
  logic [LEN_W-1:0]           new_lo, new_cnt, new_step, probe_idx;

  assign len_idx = (state_r == sli_pkg::ST_IDLE) ? LIST_W'(in_req.list_id) : list_r;
  assign len_sel = len_r[len_idx];
  assign id_ok   = (32'(in_req.list_id) < MAX_LISTS);
  assign n_cur   = (32'(other_r) > MAX_LISTS) ? CNT_W'(MAX_LISTS) : CNT_W'(other_r);

  // One step of the lower-bound search on the word read last cycle.
  assign lt        = (ram_rdata < val_r);
  assign new_lo    = lt ? (lo_r + step_r + LEN_W'(1)) : lo_r;
  assign new_cnt   = lt ? (cnt_r - step_r - LEN_W'(1)) : step_r;
  assign new_step  = new_cnt >> 1;
  assign probe_idx = new_lo + new_step;

  always_comb begin
    state_nxt     = state_r;
    ovf_nxt       = ovf_r;
    list_nxt      = list_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    cur_len_nxt   = cur_len_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    len_clr       = 1'b0;
    len_inc       = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = {list_r, lo_r[IDX_W-1:0]};

    unique case (state_r)
      sli_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_req.action)
            sli_pkg::ACT_CLEAR: begin
              len_clr = 1'b1;
              ovf_nxt = 1'b0;
            end
            sli_pkg::ACT_LOAD: begin
              if (id_ok) begin
                if (len_sel == FULL_LEN) begin
                  ovf_nxt = 1'b1;
                end else begin
                  ram_we   = 1'b1;
                  ram_addr = {len_idx, len_sel[IDX_W-1:0]};
                  len_inc  = 1'b1;
                end
              end
            end
            sli_pkg::ACT_PROBE: begin
              val_nxt = in_req.value;
              if (n_cur == '0) begin
                out_valid_nxt = 1'b1;
                out_res_nxt   = '{probe_value: in_req.value, in_all: 1'b1,
                                  overflow_seen: ovf_r};
              end else begin
                list_nxt  = '0;
                n_nxt     = n_cur;
                state_nxt = sli_pkg::ST_START;
              end
            end
            default: ;
          endcase
        end
      end

      sli_pkg::ST_START: begin
        cur_len_nxt = len_sel;
        lo_nxt      = '0;
        cnt_nxt     = len_sel;
        step_nxt    = len_sel >> 1;
        ram_addr    = {list_r, step_nxt[IDX_W-1:0]};
        if (len_sel == '0) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{probe_value: val_r, in_all: 1'b0, overflow_seen: ovf_r};
          state_nxt     = sli_pkg::ST_IDLE;
        end else begin
          state_nxt = sli_pkg::ST_SRCH;
        end
      end

      sli_pkg::ST_SRCH: begin
        lo_nxt = new_lo;
        if (new_cnt != '0) begin
          cnt_nxt  = new_cnt;
          step_nxt = new_step;
          ram_addr = {list_r, probe_idx[IDX_W-1:0]};
        end else if (new_lo < cur_len_r) begin
          ram_addr  = {list_r, new_lo[IDX_W-1:0]};
          state_nxt = sli_pkg::ST_CHECK;
        end else begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{probe_value: val_r, in_all: 1'b0, overflow_seen: ovf_r};
          state_nxt     = sli_pkg::ST_IDLE;
        end
      end

      sli_pkg::ST_CHECK: begin
        if (ram_rdata == val_r) begin
          if ((CNT_W'(list_r) + CNT_W'(1)) == n_r) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = '{probe_value: val_r, in_all: 1'b1, overflow_seen: ovf_r};
            state_nxt     = sli_pkg::ST_IDLE;
          end else begin
            list_nxt  = list_r + LIST_W'(1);
            state_nxt = sli_pkg::ST_START;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{probe_value: val_r, in_all: 1'b0, overflow_seen: ovf_r};
          state_nxt     = sli_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sli_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sli_pkg::ST_IDLE;
      ovf_r       <= 1'b0;
      other_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_LISTS; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        other_r <= cfg_data;
      end
      if (len_clr) begin
        for (int i = 0; i < MAX_LISTS; i++) begin
          len_r[i] <= '0;
        end
      end else if (len_inc) begin
        len_r[len_idx] <= len_sel + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    list_r    <= list_nxt;
    n_r       <= n_nxt;
    lo_r      <= lo_nxt;
    cnt_r     <= cnt_nxt;
    step_r    <= step_nxt;
    cur_len_r <= cur_len_nxt;
    val_r     <= val_nxt;
    out_res_r <= out_res_nxt;
  end

  // Writes happen only in idle and read data is used only during a search, so
  // the single port never has to serve both at once.
  sli_ram #(
    .WIDTH (sli_pkg::VALUE_W),
    .DEPTH (2 ** AW)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_req.value),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != sli_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### rtl/core/sli_ram.sv
// Generic single-port RAM with registered read data.
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/sli_checker.sv
// Port-level assertions of the sorted list intersection block and their bind.
`include "sorted_list_intersection_macros.svh"

module sli_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input sli_pkg::sli_in_t in_req,
  input logic             out_valid
);

  logic accepted;
  logic probe_taken;
  assign accepted    = start && !busy;
  assign probe_taken = accepted && (in_req.action == sli_pkg::ACT_PROBE);

  // A result comes only from a search in flight or a probe taken last cycle.
  `SLI_ASSERT_IMPL(a_result_has_source, clk, rst_n, out_valid, $past(busy || probe_taken))

  // Clear and load requests never produce a result.
  `SLI_ASSERT_NEXT(a_no_result_for_update, clk, rst_n, accepted && !probe_taken, !out_valid)

  // The result of a search ends it: the block is free again.
  `SLI_ASSERT_IMPL(a_result_ends_search, clk, rst_n, busy ##1 out_valid, !busy)

endmodule

bind sorted_list_intersection sli_checker u_sli_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the sorted list intersection engine.
`timescale 1ns / 1ps

module testbench;

  localparam int LISTS = sli_pkg::MAX_LISTS_DEF;
  localparam int DEPTH = sli_pkg::LIST_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [sli_pkg::ACT_W-1:0] ACT_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  sli_pkg::sli_in_t in_req;
  logic out_valid;
  sli_pkg::sli_out_t out_res;
  logic cfg_valid;
  logic cfg_ready;
  logic [sli_pkg::CFG_W-1:0] cfg_data;

  // Mirror of the engine state
  bit [sli_pkg::VALUE_W-1:0] list_words [LISTS][DEPTH];
  int unsigned list_fill [LISTS];
  bit drop_flag;
  bit [sli_pkg::CFG_W-1:0] search_lists;

  sli_pkg::sli_out_t pending_results[$];
  sli_pkg::sli_out_t want;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned idle_pct;
  int unsigned random_items;

  sorted_list_intersection dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sorted_list_intersection] ERROR");
      $finish;
    end
  end

  // Lower-bound search; found when the bound entry equals the value.
  function automatic bit lower_bound_hit(int which, bit [sli_pkg::VALUE_W-1:0] v);
    int unsigned lo;
    int unsigned count;
    int unsigned step;
    int unsigned len;
    lo = 0;
    len = list_fill[which];
    count = len;
    while (count > 0) begin
      step = count / 2;
      if (list_words[which][lo + step] < v) begin
        lo += step + 1;
        count -= step + 1;
      end else begin
        count = step;
      end
    end
    return (lo < len) && (list_words[which][lo] == v);
  endfunction

  function automatic void predict_request(sli_pkg::sli_in_t r);
    sli_pkg::sli_out_t res;
    int n;
    bit all;
    case (r.action)
      sli_pkg::ACT_CLEAR: begin
        foreach (list_fill[i]) list_fill[i] = 0;
        drop_flag = 1'b0;
      end
      sli_pkg::ACT_LOAD: begin
        if (r.list_id < LISTS) begin
          if (list_fill[r.list_id] >= DEPTH) begin
            drop_flag = 1'b1;
          end else begin
            list_words[r.list_id][list_fill[r.list_id]] = r.value;
            list_fill[r.list_id]++;
          end
        end
      end
      sli_pkg::ACT_PROBE: begin
        n = (search_lists > LISTS) ? LISTS : search_lists;
        all = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (!lower_bound_hit(i, r.value)) begin
            all = 1'b0;
            break;
          end
        end
        res.probe_value = r.value;
        res.in_all = all;
        res.overflow_seen = drop_flag;
        pending_results.insert(pending_results.size(), res);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no probe pending: probe_value %h", out_res.probe_value);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_res.probe_value !== want.probe_value) begin
          $error("probe_value: expected %h, got %h", want.probe_value, out_res.probe_value);
          mismatch_count++;
        end
        if (out_res.in_all !== want.in_all) begin
          $error("in_all: expected %b, got %b", want.in_all, out_res.in_all);
          mismatch_count++;
        end
        if (out_res.overflow_seen !== want.overflow_seen) begin
          $error("overflow_seen: expected %b, got %b", want.overflow_seen,
                 out_res.overflow_seen);
          mismatch_count++;
        end
      end
    end
  end

  function automatic sli_pkg::sli_in_t make_req(logic [sli_pkg::ACT_W-1:0] act,
                                                logic [sli_pkg::ID_W-1:0] id,
                                                logic [sli_pkg::VALUE_W-1:0] v);
    sli_pkg::sli_in_t r;
    r.action = act;
    r.list_id = id;
    r.value = v;
    return r;
  endfunction

  // Hold the request until the engine takes it, then, with a chance of idle_pct percent, leave a random gap.
  task automatic issue(sli_pkg::sli_in_t r);
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    predict_request(r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_results_done();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_other_lists(logic [sli_pkg::CFG_W-1:0] v);
    wait_results_done();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    search_lists = v;
  endtask

  task automatic test_directed();
    write_other_lists(4'd0);
    // nothing configured: every probe is found
    issue(make_req(sli_pkg::ACT_PROBE, 3'd0, 32'h0000_0000));
    issue(make_req(sli_pkg::ACT_PROBE, 3'd7, 32'hFFFF_FFFF));
    issue(make_req(ACT_NONE, 3'd5, 32'hA5A5_A5A5));
    for (int l = 0; l < LISTS; l++) begin
      issue(make_req(sli_pkg::ACT_LOAD, 3'(l), 32'h0000_0000));
      issue(make_req(sli_pkg::ACT_LOAD, 3'(l), 32'hFFFF_FFFF));
    end
    // unsorted tail on list 0
    issue(make_req(sli_pkg::ACT_LOAD, 3'd0, 32'h1234_5678));
    write_other_lists(4'd15);
    issue(make_req(sli_pkg::ACT_PROBE, 3'd0, 32'h0000_0000));
    issue(make_req(sli_pkg::ACT_PROBE, 3'd0, 32'hFFFF_FFFF));
    issue(make_req(sli_pkg::ACT_PROBE, 3'd0, 32'h1234_5678));
    issue(make_req(sli_pkg::ACT_PROBE, 3'd0, 32'h0000_0001));
    write_other_lists(4'd8);
    issue(make_req(sli_pkg::ACT_PROBE, 3'd2, 32'h0000_0000));
  endtask

  task automatic test_list_overflow();
    issue(make_req(sli_pkg::ACT_CLEAR, 3'd0, 32'h0));
    write_other_lists(4'd1);
    for (int i = 0; i < DEPTH + 3; i++)
      issue(make_req(sli_pkg::ACT_LOAD, 3'd0, 32'(i * 16)));
    issue(make_req(sli_pkg::ACT_LOAD, 3'd4, 32'h0000_0040));
    issue(make_req(sli_pkg::ACT_PROBE, 3'd0, 32'(1000 * 16)));
    issue(make_req(sli_pkg::ACT_PROBE, 3'd0, 32'(1000 * 16 + 1)));
    issue(make_req(sli_pkg::ACT_PROBE, 3'd0, 32'(DEPTH * 16)));
    issue(make_req(sli_pkg::ACT_PROBE, 3'd0, 32'((DEPTH - 1) * 16)));
    write_other_lists(4'd8);
    issue(make_req(sli_pkg::ACT_PROBE, 3'd0, 32'h0000_0000));
    issue(make_req(sli_pkg::ACT_CLEAR, 3'd0, 32'h0));
    issue(make_req(sli_pkg::ACT_PROBE, 3'd0, 32'h0000_0040));
  endtask

  task automatic run_random_set();
    bit [sli_pkg::VALUE_W-1:0] pool[$];
    bit [sli_pkg::VALUE_W-1:0] order[$];
    bit [sli_pkg::VALUE_W-1:0] v;
    if ($urandom_range(3) == 0)
      write_other_lists(($urandom_range(9) == 0) ? sli_pkg::CFG_W'($urandom_range(15, 9))
                                                 : sli_pkg::CFG_W'($urandom_range(8)));
    // skip the clear now and then so lists keep growing across sets
    if ($urandom_range(7) != 0) begin
      issue(make_req(sli_pkg::ACT_CLEAR, 3'($urandom), $urandom));
      random_items++;
    end
    repeat (6) begin
      case ($urandom_range(3))
        0: v = $urandom_range(15);
        1: v = 32'hFFFF_FFFF - $urandom_range(15);
        default: v = $urandom;
      endcase
      pool.insert(pool.size(), v);
    end
    pool.sort();
    for (int l = 0; l < LISTS; l++) begin
      order.delete();
      foreach (pool[i]) if ($urandom_range(3) != 0) order.insert(order.size(), pool[i]);
      if ($urandom_range(9) == 0) order.shuffle();
      foreach (order[i]) begin
        issue(make_req(sli_pkg::ACT_LOAD, 3'(l), order[i]));
        random_items++;
      end
    end
    repeat (12) begin
      case ($urandom_range(9))
        6, 7: issue(make_req(sli_pkg::ACT_PROBE, 3'($urandom), $urandom));
        8: issue(make_req(sli_pkg::ACT_PROBE, 3'($urandom), pool[$urandom_range(5)] + 1));
        9: begin
          // noise: ignored action or a stray load
          if ($urandom_range(1) == 0)
            issue(make_req(ACT_NONE, 3'($urandom), $urandom));
          else
            issue(make_req(sli_pkg::ACT_LOAD, 3'($urandom), $urandom));
          random_items--;
        end
        default: issue(make_req(sli_pkg::ACT_PROBE, 3'($urandom), pool[$urandom_range(5)]));
      endcase
      random_items++;
    end
    if ($urandom_range(4) == 0) wait_results_done();
  endtask

  task automatic test_random_traffic(int unsigned count);
    random_items = 0;
    while (random_items < count) run_random_set();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_list_overflow();
    idle_pct = 13;
    test_random_traffic(170);
    idle_pct = 80;
    test_random_traffic(170);
    idle_pct = 0;
    test_random_traffic(170);
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("[sorted_list_intersection] OK");
    else
      $display("[sorted_list_intersection] ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/sli_pkg.sv
rtl/core/sli_ram.sv
rtl/core/sorted_list_intersection.sv
rtl/core/sli_checker.sv
tb/testbench.sv
